// ----- design/adjacency_matrix_dfs_order_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix depth-first traversal block
// Shared property templates; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_DFS_ORDER_DEFINES_SVH
`define ADJACENCY_MATRIX_DFS_ORDER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define AMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define AMD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

`endif

// ----- design/amd_pkg.sv -----
// ----------------------------------------------------------------------------
// Package for the adjacency matrix depth-first traversal block
// Command codes, controller states and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amd_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [31:0] NO_EDGE_WEIGHT = 32'h0000_8000;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LABEL = 2'd1,
    CMD_EDGE  = 2'd2,
    CMD_WALK  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LK_RD,
    ST_LK_CMP,
    ST_A_RD,
    ST_A_WR,
    ST_B_RD,
    ST_B_WR,
    ST_T_START,
    ST_T_LBL,
    ST_T_ROWRD,
    ST_T_ROWQ,
    ST_T_POPRD,
    ST_T_POP,
    ST_FLUSH
  } state_t;

endpackage

// ----- design/adjacency_matrix_dfs_order.sv -----
// ----------------------------------------------------------------------------
// Adjacency matrix depth-first traversal
// Holds an undirected graph as a bit matrix in block memory and walks it
// depth first with a stack memory, streaming out vertex labels.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         command transaction (tuser: cmd)
// m_*       out        visited vertex label, tlast on the final one
// cfg_*     in         vertex_count write
//
// Clear and set-label commands complete in the idle state. Add-edge runs a
// label search over the n slots, then a row read-modify-write of both ends
// on the matrix port. Traverse fetches a label, reads a row and picks a
// candidate per visit, reads and pops the stack per backtrack, steps over each
// visited start, limited by the single matrix read port and label memory.
// Reset is synchronous; edge and label valid bits clear at once, no sweep.
// A stalled output holds the walk at the next visit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adjacency_matrix_dfs_order
  import amd_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // vertex_slot[5:0], label[13:6], end_a_label[21:14], end_b_label[29:22],
  // edge_weight[61:30], zero[63:62]
  input  logic [63:0] s_tdata,
  // cmd[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // visit_label[7:0]
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int MV = MAX_VERTICES;
  localparam int IW = (MV > 1) ? $clog2(MV) : 1;
  localparam int CW = $clog2(MV + 1);
  localparam logic [6:0] MV7 = 7'(MV);

  state_t state, state_next;

  logic [6:0]    vertex_count;
  logic [CW-1:0] n;
  logic [CW-1:0] k, start, sp;
  logic [CW-1:0] k_inc;
  logic [IW-1:0] ia, ib, top;
  logic          fa, fb, no_edge;
  logic [7:0]    lab_a, lab_b;
  logic [MV-1:0] visited, adj_valid, lbl_valid;

  logic [MV-1:0] adj_mem [MV];
  logic [7:0]    lbl_mem [MV];
  logic [IW-1:0] stk_mem [MV];

  logic [MV-1:0] adj_q;
  logic          adj_qv;
  logic [7:0]    lbl_q;
  logic          lbl_qv;
  logic [IW-1:0] stk_q;

  logic          adj_re, adj_we, lbl_re, lbl_we, stk_re, stk_we;
  logic [IW-1:0] adj_ra, adj_wa, lbl_ra, lbl_wa, stk_ra, stk_wa, vnew;
  logic [MV-1:0] adj_wd, row_eff, nmask, cand;
  logic [7:0]    lv;
  logic          in_acc, out_free, emit_ok, visit, cand_any, slot_ok;
  logic [IW-1:0] cand_idx;
  cmd_t          in_cmd;
  logic [7:0]    pend;
  logic          pend_valid;
  logic          out_load;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign in_cmd    = cmd_t'(s_tuser);
  assign n         = (vertex_count > MV7) ? CW'(MV) : CW'(vertex_count);
  assign k_inc     = k + CW'(1);
  assign out_free  = !m_tvalid || m_tready;
  assign emit_ok   = !pend_valid || out_free;
  assign row_eff   = adj_qv ? adj_q : '0;
  assign lv        = lbl_qv ? lbl_q : 8'd0;
  assign slot_ok   = {1'b0, s_tdata[5:0]} < MV7;
  assign out_load  = ((state == ST_T_LBL) && emit_ok && pend_valid) ||
                     ((state == ST_FLUSH) && out_free);

  always_comb begin
    for (int j = 0; j < MV; j++) begin
      nmask[j] = CW'(j) < n;
    end
    cand = row_eff & ~visited & nmask;
    cand_any = 1'b0;
    cand_idx = '0;
    for (int j = MV - 1; j >= 0; j--) begin
      if (cand[j]) begin
        cand_any = 1'b1;
        cand_idx = IW'(j);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_EDGE: state_next = (n == '0) ? ST_A_RD : ST_LK_RD;
            CMD_WALK: state_next = (n == '0) ? ST_IDLE : ST_T_START;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LK_RD:  state_next = ST_LK_CMP;
      ST_LK_CMP: state_next = (k_inc == n) ? ST_A_RD : ST_LK_RD;
      ST_A_RD:   state_next = ST_A_WR;
      ST_A_WR:   state_next = ST_B_RD;
      ST_B_RD:   state_next = ST_B_WR;
      ST_B_WR:   state_next = ST_IDLE;
      ST_T_START: begin
        if (start == n) begin
          state_next = ST_FLUSH;
        end else if (!visited[start[IW-1:0]]) begin
          state_next = ST_T_LBL;
        end
      end
      ST_T_LBL:   state_next = emit_ok ? ST_T_ROWRD : ST_T_LBL;
      ST_T_ROWRD: state_next = ST_T_ROWQ;
      ST_T_ROWQ: begin
        if (cand_any) begin
          state_next = ST_T_LBL;
        end else if (sp == CW'(1)) begin
          state_next = ST_T_START;
        end else begin
          state_next = ST_T_POPRD;
        end
      end
      ST_T_POPRD: state_next = ST_T_POP;
      ST_T_POP:   state_next = ST_T_ROWRD;
      ST_FLUSH:   state_next = out_free ? ST_IDLE : ST_FLUSH;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    adj_re = 1'b0;
    adj_ra = top;
    adj_we = 1'b0;
    adj_wa = ia;
    adj_wd = row_eff;
    lbl_re = 1'b0;
    lbl_ra = k[IW-1:0];
    lbl_we = 1'b0;
    lbl_wa = IW'(s_tdata[5:0]);
    stk_re = 1'b0;
    stk_ra = sp[IW-1:0] - IW'(1);
    stk_we = 1'b0;
    stk_wa = sp[IW-1:0];
    visit  = 1'b0;
    vnew   = start[IW-1:0];
    case (state)
      ST_IDLE: begin
        lbl_we = in_acc && (in_cmd == CMD_LABEL) && slot_ok;
      end
      ST_LK_RD: begin
        lbl_re = 1'b1;
      end
      ST_A_RD: begin
        adj_re = 1'b1;
        adj_ra = ia;
      end
      ST_A_WR: begin
        adj_we = 1'b1;
        adj_wa = ia;
        adj_wd = no_edge ? (row_eff & ~(MV'(1) << ib)) : (row_eff | (MV'(1) << ib));
      end
      ST_B_RD: begin
        adj_re = 1'b1;
        adj_ra = ib;
      end
      ST_B_WR: begin
        adj_we = 1'b1;
        adj_wa = ib;
        adj_wd = no_edge ? (row_eff & ~(MV'(1) << ia)) : (row_eff | (MV'(1) << ia));
      end
      ST_T_START: begin
        visit = (start != n) && !visited[start[IW-1:0]];
      end
      ST_T_ROWRD: begin
        adj_re = 1'b1;
        adj_ra = top;
      end
      ST_T_ROWQ: begin
        visit = cand_any;
        vnew  = cand_idx;
      end
      ST_T_POPRD: begin
        stk_re = 1'b1;
      end
      default: begin
      end
    endcase
    if (visit) begin
      lbl_re = 1'b1;
      lbl_ra = vnew;
      stk_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_q  <= adj_mem[adj_ra];
      adj_qv <= adj_valid[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (lbl_we) begin
      lbl_mem[lbl_wa] <= s_tdata[13:6];
    end
    if (lbl_re) begin
      lbl_q  <= lbl_mem[lbl_ra];
      lbl_qv <= lbl_valid[lbl_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= vnew;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      adj_valid    <= '0;
      lbl_valid    <= '0;
      visited      <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
      m_tdata      <= '0;
      sp           <= '0;
      start        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (lbl_we) begin
        lbl_valid[lbl_wa] <= 1'b1;
      end
      if (adj_we) begin
        adj_valid[adj_wa] <= 1'b1;
      end
      if (visit) begin
        visited[vnew] <= 1'b1;
        sp            <= sp + CW'(1);
        top           <= vnew;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            lab_a   <= s_tdata[21:14];
            lab_b   <= s_tdata[29:22];
            no_edge <= (s_tdata[61:30] == NO_EDGE_WEIGHT);
            k       <= '0;
            fa      <= 1'b0;
            fb      <= 1'b0;
            ia      <= '0;
            ib      <= '0;
            start   <= '0;
            sp      <= '0;
            if (in_cmd == CMD_CLEAR) begin
              adj_valid <= '0;
            end
            if (in_cmd == CMD_WALK) begin
              visited <= '0;
            end
          end
        end
        ST_LK_CMP: begin
          k <= k_inc;
          if (!fa && lv == lab_a) begin
            fa <= 1'b1;
            ia <= k[IW-1:0];
          end
          if (!fb && lv == lab_b) begin
            fb <= 1'b1;
            ib <= k[IW-1:0];
          end
        end
        ST_T_START: begin
          if (start != n && visited[start[IW-1:0]]) begin
            start <= start + CW'(1);
          end
        end
        ST_T_LBL: begin
          if (emit_ok) begin
            if (pend_valid) begin
              m_tdata  <= pend;
              m_tlast  <= 1'b0;
            end
            pend       <= lv;
            pend_valid <= 1'b1;
          end
        end
        ST_T_ROWQ: begin
          if (!cand_any) begin
            sp <= sp - CW'(1);
            if (sp == CW'(1)) begin
              start <= start + CW'(1);
            end
          end
        end
        ST_T_POP: begin
          top <= stk_q;
        end
        ST_FLUSH: begin
          if (out_free) begin
            m_tdata    <= pend;
            m_tlast    <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- design/amd_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker for the adjacency matrix depth-first traversal block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adjacency_matrix_dfs_order_defines.svh"

module amd_checker
  import amd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);

  `AMD_ASSERT_NEXT(out_holds, m_tvalid && !m_tready, m_tvalid)
  `AMD_ASSERT_NEXT(out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `AMD_ASSERT_NEXT(edge_busy, s_tvalid && s_tready && s_tuser == CMD_EDGE, !s_tready)
  `AMD_ASSERT_NEXT(label_fast, s_tvalid && s_tready && s_tuser == CMD_LABEL, s_tready)

endmodule

bind adjacency_matrix_dfs_order amd_checker u_amd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
